FILE: rtl/core/qrfp_pkg.sv
// Shared types, constants and helper functions for the QR function-pattern query.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps
`default_nettype none
package qrfp_pkg;

  // Widths fixed by the field definitions
  localparam int unsigned VerW   = 6;
  localparam int unsigned EccW   = 2;
  localparam int unsigned MaskW  = 3;
  localparam int unsigned DtypeW = 3;
  localparam int unsigned CoordW = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  localparam int unsigned MaxVersionDef = 40;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_VERSION = 2'd0,
    CFG_ECC     = 2'd1,
    CFG_MASK    = 2'd2,
    CFG_DTYPE   = 2'd3
  } cfg_idx_e;

  // Data-type corner codes
  localparam logic [DtypeW-1:0] DT_NONE   = 3'd0;
  localparam logic [DtypeW-1:0] DT_S2_S2  = 3'd1;
  localparam logic [DtypeW-1:0] DT_S2_S1  = 3'd2;
  localparam logic [DtypeW-1:0] DT_S1_S1  = 3'd3;
  localparam logic [DtypeW-1:0] DT_S1_S2  = 3'd4;

  // Symbol geometry and format settings handed to the evaluator
  typedef struct packed {
    logic [VerW-1:0]   ver;    // clamped version
    logic [CoordW-1:0] side;   // 4*ver+17
    logic [EccW-1:0]   ecc;
    logic [MaskW-1:0]  mask;
    logic [DtypeW-1:0] dtype;
  } geom_t;

  // Finder pattern lookup on a local 0..6 coordinate pair
  function automatic logic finder_hit(logic [2:0] a, logic [2:0] b);
    logic edge_a;
    logic edge_b;
    logic core_a;
    logic core_b;
    edge_a = (a == 3'd0) || (a == 3'd6);
    edge_b = (b == 3'd0) || (b == 3'd6);
    core_a = (a >= 3'd2) && (a <= 3'd4);
    core_b = (b >= 3'd2) && (b <= 3'd4);
    return edge_a || edge_b || (core_a && core_b);
  endfunction

  function automatic logic [CoordW-1:0] abs_diff(logic [CoordW-1:0] a,
                                                 logic [CoordW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Alignment ring: Chebyshev distance of 0 or 2 from the centre
  function automatic logic ring_hit(logic [CoordW-1:0] dr, logic [CoordW-1:0] dc);
    return ((dr == 8'd0) && (dc == 8'd0)) ||
           ((dr == 8'd2) && (dc <= 8'd2)) ||
           ((dc == 8'd2) && (dr <= 8'd2));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/qr_function_pattern_module_top.sv
// done_o and the result come from the result register, fed by the input register that
// captures each start transfer.
// Throughput: one query per cycle; busy stays low, start may be high every cycle.
// Set by one input register and one result register around combinational logic.
// Reset clears the configuration (version 1, other codes 0) and the valid flags.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Top level of the QR function-pattern query; depends on qrfp_pkg, qrfp_cfg, qrfp_eval.
`timescale 1ns / 1ps
`default_nettype none
module qr_function_pattern_module_top
  import qrfp_pkg::*;
#(
  parameter int unsigned MAX_VERSION = MaxVersionDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CoordW-1:0]   row_i,
  input  wire logic [CoordW-1:0]   col_i,
  output logic                     done_o,
  output logic                     dark_o,
  output logic                     out_of_range_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  geom_t             geom;
  logic              in_vld_q;
  logic [CoordW-1:0] row_q, col_q;
  logic              dark_d, oor_d;
  logic              done_q, dark_q, oor_q;
  logic              take;

  // Never stalls the sender
  assign busy = 1'b0;
  assign take = start && !busy;

  qrfp_cfg #(
    .MAX_VERSION(MAX_VERSION)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .geom_o     (geom)
  );

  // Capture the query on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      row_q <= row_i;
      col_q <= col_i;
    end
  end

  qrfp_eval u_eval (
    .row_i         (row_q),
    .col_i         (col_q),
    .geom_i        (geom),
    .dark_o        (dark_d),
    .out_of_range_o(oor_d)
  );

  // Register the result and its strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      dark_q <= dark_d;
      oor_q  <= oor_d;
    end
  end

  assign done_o         = done_q;
  assign dark_o         = dark_q;
  assign out_of_range_o = oor_q;

endmodule
`default_nettype wire

FILE: rtl/core/qrfp_cfg.sv
// Configuration register file: version, ECC level, mask and data-type codes.
// Clamps the version and derives the side length. Depends on qrfp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qrfp_cfg
  import qrfp_pkg::*;
#(
  parameter int unsigned MAX_VERSION = MaxVersionDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output geom_t                    geom_o
);

  logic [VerW-1:0]   ver_q;
  logic [EccW-1:0]   ecc_q;
  logic [MaskW-1:0]  mask_q;
  logic [DtypeW-1:0] dtype_q;
  logic [VerW-1:0]   ver_clamped;

  // Take register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_q   <= VerW'(1);
      ecc_q   <= '0;
      mask_q  <= '0;
      dtype_q <= DT_NONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_VERSION: ver_q   <= cfg_wdata_i[VerW-1:0];
        CFG_ECC:     ecc_q   <= cfg_wdata_i[EccW-1:0];
        CFG_MASK:    mask_q  <= cfg_wdata_i[MaskW-1:0];
        CFG_DTYPE:   dtype_q <= cfg_wdata_i[DtypeW-1:0];
        default:     ;
      endcase
    end
  end

  // Clamp version into 1..MAX_VERSION
  always_comb begin
    if (ver_q == '0) begin
      ver_clamped = VerW'(1);
    end else if (ver_q > VerW'(MAX_VERSION)) begin
      ver_clamped = VerW'(MAX_VERSION);
    end else begin
      ver_clamped = ver_q;
    end
  end

  assign geom_o.ver   = ver_clamped;
  assign geom_o.side  = {ver_clamped, 2'b00} + CoordW'(17);
  assign geom_o.ecc   = ecc_q;
  assign geom_o.mask  = mask_q;
  assign geom_o.dtype = dtype_q;

endmodule
`default_nettype wire

FILE: rtl/core/qrfp_eval.sv
// Combinational module classifier: finders, alignment, timing, dark module, format and corner bits.
// Depends on qrfp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qrfp_eval
  import qrfp_pkg::*;
(
  input  wire logic [CoordW-1:0] row_i,
  input  wire logic [CoordW-1:0] col_i,
  input  geom_t                  geom_i,
  output logic                   dark_o,
  output logic                   out_of_range_o
);

  logic [CoordW-1:0] side;
  logic [CoordW-1:0] sm1, sm2, sm3, sm4, sm5, sm7, sm8;
  logic [CoordW-1:0] g1;
  logic [CoordW-1:0] dr0, dr1, dr2, dc0, dc1, dc2;
  logic [CoordW-1:0] row_bl, col_tr;
  logic              finder, align, timing, dark_mod, fmt, corner;
  logic              align_on, align_single, align_grid;

  assign side = geom_i.side;
  assign sm1  = side - CoordW'(1);
  assign sm2  = side - CoordW'(2);
  assign sm3  = side - CoordW'(3);
  assign sm4  = side - CoordW'(4);
  assign sm5  = side - CoordW'(5);
  assign sm7  = side - CoordW'(7);
  assign sm8  = side - CoordW'(8);

  assign out_of_range_o = (row_i >= side) || (col_i >= side);

  // Finder patterns: top-left, bottom-left, top-right (pattern is mirror symmetric)
  assign row_bl = row_i - sm7;
  assign col_tr = col_i - sm7;
  always_comb begin
    finder = 1'b0;
    if ((row_i < 8'd7) && (col_i < 8'd7)) begin
      finder = finder_hit(row_i[2:0], col_i[2:0]);
    end
    if ((row_i >= sm7) && (col_i < 8'd7)) begin
      finder = finder | finder_hit(row_bl[2:0], col_i[2:0]);
    end
    if ((row_i < 8'd7) && (col_i >= sm7)) begin
      finder = finder | finder_hit(row_i[2:0], col_tr[2:0]);
    end
  end

  // Alignment centres: grid {6, 2v+8, side-7}; v%7 equals v-7 over versions 7..13
  assign g1  = CoordW'({geom_i.ver, 1'b0}) + CoordW'(8);
  assign dr0 = abs_diff(row_i, CoordW'(6));
  assign dr1 = abs_diff(row_i, g1);
  assign dr2 = abs_diff(row_i, sm7);
  assign dc0 = abs_diff(col_i, CoordW'(6));
  assign dc1 = abs_diff(col_i, g1);
  assign dc2 = abs_diff(col_i, sm7);

  assign align_on     = (geom_i.ver >= VerW'(2)) && (geom_i.ver <= VerW'(13));
  assign align_single = ring_hit(dr2, dc2);
  // Skip the centres that land on the finders
  assign align_grid   = ring_hit(dr0, dc1) || ring_hit(dr1, dc0) || ring_hit(dr1, dc1) ||
                        ring_hit(dr1, dc2) || ring_hit(dr2, dc1) || ring_hit(dr2, dc2);
  assign align = align_on &&
                 ((geom_i.ver < VerW'(7)) ? align_single : align_grid);

  // Timing lines on row and column 6
  assign timing = ((row_i == 8'd6) && (col_i >= 8'd7) && (col_i < sm7) && !col_i[0]) ||
                  ((col_i == 8'd6) && (row_i >= 8'd7) && (row_i < sm7) && !row_i[0]);

  assign dark_mod = (row_i == sm8) && (col_i == 8'd8);

  // Format bits: ECC level and mask
  always_comb begin
    fmt = 1'b0;
    if (geom_i.ecc[0] && (((row_i == 8'd8) && (col_i == 8'd1)) ||
                          ((row_i == sm2) && (col_i == 8'd8)))) fmt = 1'b1;
    if (geom_i.ecc[1] && (((row_i == 8'd8) && (col_i == 8'd0)) ||
                          ((row_i == sm1) && (col_i == 8'd8)))) fmt = 1'b1;
    if (geom_i.mask[0] && (((row_i == 8'd8) && (col_i == 8'd4)) ||
                           ((row_i == sm5) && (col_i == 8'd8)))) fmt = 1'b1;
    if (geom_i.mask[1] && (((row_i == 8'd8) && (col_i == 8'd3)) ||
                           ((row_i == sm4) && (col_i == 8'd8)))) fmt = 1'b1;
    if (geom_i.mask[2] && (((row_i == 8'd8) && (col_i == 8'd2)) ||
                           ((row_i == sm3) && (col_i == 8'd8)))) fmt = 1'b1;
  end

  // Data-type corner module
  always_comb begin
    unique case (geom_i.dtype)
      DT_S2_S2: corner = (row_i == sm2) && (col_i == sm2);
      DT_S2_S1: corner = (row_i == sm2) && (col_i == sm1);
      DT_S1_S1: corner = (row_i == sm1) && (col_i == sm1);
      DT_S1_S2: corner = (row_i == sm1) && (col_i == sm2);
      default:  corner = 1'b0;
    endcase
  end

  assign dark_o = !out_of_range_o &&
                  (finder || align || timing || dark_mod || fmt || corner);

endmodule
`default_nettype wire

FILE: tb/sv/tb_qr_function_pattern_module_top.sv
// Self-checking bench for qr_function_pattern_module_top: module queries against a pattern predictor.
// Depends on qrfp_pkg and the RTL under rtl/core; drives configuration phases and random queries.
`timescale 1ns / 1ps
module tb_qr_function_pattern_module_top;
  import qrfp_pkg::*;

  localparam int WatchdogLimit = 500;
  localparam int QueriesPerPhase = 90;
  localparam int PhaseCount = 12;
  localparam int DirectedCount = 26;

  typedef struct {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic              dark;
    logic              out_of_range;
  } module_answer_t;

  // Track configuration, predict each queried module and match the answers in order
  class pattern_scoreboard;
    logic [VerW-1:0]   version_reg = 1;
    logic [EccW-1:0]   ecc_reg = '0;
    logic [MaskW-1:0]  mask_reg = '0;
    logic [DtypeW-1:0] dtype_reg = '0;
    module_answer_t    pending_answers[$];
    int                mismatch_count = 0;

    static function bit finder_cell(int r, int c);
      if (r < 0 || r > 6 || c < 0 || c > 6) return 1'b0;
      if (r == 0 || r == 6 || c == 0 || c == 6) return 1'b1;
      return r >= 2 && r <= 4 && c >= 2 && c <= 4;
    endfunction

    // Chebyshev distance 0 or 2 from an alignment centre
    static function bit on_ring(int r, int c, int pr, int pc);
      int dr;
      int dc;
      dr = (r > pr) ? r - pr : pr - r;
      dc = (c > pc) ? c - pc : pc - c;
      return (dr > dc ? dr : dc) == 0 || (dr > dc ? dr : dc) == 2;
    endfunction

    function void note_config(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_VERSION: version_reg = data[VerW-1:0];
        CFG_ECC:     ecc_reg = data[EccW-1:0];
        CFG_MASK:    mask_reg = data[MaskW-1:0];
        CFG_DTYPE:   dtype_reg = data[DtypeW-1:0];
        default: ;
      endcase
    endfunction

    function void note_query(logic [CoordW-1:0] row_in, logic [CoordW-1:0] col_in);
      module_answer_t ans;
      int v;
      int s;
      int r;
      int c;
      bit d;
      int grid[3];
      v = version_reg;
      if (v < 1) v = 1;
      if (v > MaxVersionDef) v = MaxVersionDef;
      s = 4 * v + 17;
      r = row_in;
      c = col_in;
      ans.row = row_in;
      ans.col = col_in;
      d = 1'b0;
      if (r >= s || c >= s) begin
        ans.dark = 1'b0;
        ans.out_of_range = 1'b1;
        pending_answers.push_back(ans);
        return;
      end
      // finders
      if (finder_cell(r, c) || finder_cell(s - 1 - r, c) || finder_cell(r, s - 1 - c)) d = 1'b1;
      // alignment rings
      if (v >= 2 && v <= 13) begin
        if (v < 7) begin
          if (on_ring(r, c, s - 7, s - 7)) d = 1'b1;
        end else begin
          grid[0] = 6;
          grid[1] = 22 + 2 * (v % 7);
          grid[2] = 18 + 4 * (v - 2);
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
              if ((i == 0 && j == 0) || (i == 0 && j == 2) || (i == 2 && j == 0)) continue;
              if (on_ring(r, c, grid[i], grid[j])) d = 1'b1;
            end
          end
        end
      end
      // timing lines
      if (r == 6 && c >= 7 && c < s - 7 && (c % 2) == 0) d = 1'b1;
      if (c == 6 && r >= 7 && r < s - 7 && (r % 2) == 0) d = 1'b1;
      // dark module
      if (r == s - 8 && c == 8) d = 1'b1;
      // format bits
      if (ecc_reg[0] && ((r == 8 && c == 1) || (r == s - 2 && c == 8))) d = 1'b1;
      if (ecc_reg[1] && ((r == 8 && c == 0) || (r == s - 1 && c == 8))) d = 1'b1;
      if (mask_reg[0] && ((r == 8 && c == 4) || (r == s - 5 && c == 8))) d = 1'b1;
      if (mask_reg[1] && ((r == 8 && c == 3) || (r == s - 4 && c == 8))) d = 1'b1;
      if (mask_reg[2] && ((r == 8 && c == 2) || (r == s - 3 && c == 8))) d = 1'b1;
      // data-type corner
      case (dtype_reg)
        DT_S2_S2: if (r == s - 2 && c == s - 2) d = 1'b1;
        DT_S2_S1: if (r == s - 2 && c == s - 1) d = 1'b1;
        DT_S1_S1: if (r == s - 1 && c == s - 1) d = 1'b1;
        DT_S1_S2: if (r == s - 1 && c == s - 2) d = 1'b1;
        default: ;
      endcase
      ans.dark = d;
      ans.out_of_range = 1'b0;
      pending_answers.push_back(ans);
    endfunction

    function void check_answer(logic dark_got, logic oor_got);
      module_answer_t exp_ans;
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected answer: dark %b oor %b", dark_got, oor_got);
        return;
      end
      exp_ans = pending_answers.pop_front();
      if (dark_got !== exp_ans.dark || oor_got !== exp_ans.out_of_range) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("answer error at row %0d col %0d: expected dark %b oor %b, got dark %b oor %b",
                   exp_ans.row, exp_ans.col, exp_ans.dark, exp_ans.out_of_range,
                   dark_got, oor_got);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [CoordW-1:0]   row = '0;
  logic [CoordW-1:0]   col = '0;
  logic                done;
  logic                dark;
  logic                out_of_range;
  logic                cfg_we = 1'b0;
  cfg_idx_e            cfg_idx = CFG_VERSION;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  pattern_scoreboard sb = new();
  int unsigned transfer_count = 0;

  qr_function_pattern_module_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .row_i          (row),
    .col_i          (col),
    .done_o         (done),
    .dark_o         (dark),
    .out_of_range_o (out_of_range),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Observe register writes, query transfers and answer strobes
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.note_config(cfg_idx, cfg_wdata);
      if (start && !busy) begin
        sb.note_query(row, col);
        transfer_count++;
      end
      if (done) begin
        sb.check_answer(dark, out_of_range);
        transfer_count++;
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin
    int unsigned last_count;
    int quiet_cycles;
    last_count = 0;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk);
      if (transfer_count != last_count) begin
        last_count = transfer_count;
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  // Present one query, with an optional idle burst ahead of it; return at its transfer edge
  task automatic send_query(input logic [CoordW-1:0] r, input logic [CoordW-1:0] c,
                            input int gap_pct);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start <= 1'b1;
    row <= r;
    col <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Drain outstanding answers, then load all four registers; unused high bits get noise
  task automatic program_symbol(input int ver, input int ecc, input int mask, input int dtype);
    start <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    write_reg(CFG_VERSION, CfgDataW'(ver));
    write_reg(CFG_ECC, CfgDataW'(($urandom_range(0, 15) << EccW) | ecc));
    write_reg(CFG_MASK, CfgDataW'(($urandom_range(0, 7) << MaskW) | mask));
    write_reg(CFG_DTYPE, CfgDataW'(($urandom_range(0, 7) << DtypeW) | dtype));
    cfg_we <= 1'b0;
  endtask

  // Coordinate close to a symbol border, sometimes just past it
  function automatic int near_border(int s);
    return $urandom_range(0, 1) ? $urandom_range(0, 10) : $urandom_range(s - 11, s);
  endfunction

  // Pick a query biased toward finders, format bits, timing lines and alignment rings
  task automatic random_query(input int v, input int gap_pct);
    int s;
    int kind;
    int r;
    int c;
    int tmp;
    int grid[3];
    s = 4 * v + 17;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      r = $urandom_range(0, 255);
      c = $urandom_range(0, 255);
    end else if (kind < 20) begin
      r = $urandom_range(s, 255);
      c = $urandom_range(0, 255);
    end else if (kind < 45) begin
      r = near_border(s);
      c = near_border(s);
    end else if (kind < 60) begin
      r = $urandom_range(0, 1) ? 6 : 8;
      c = $urandom_range(0, s - 1);
    end else if (kind < 75) begin
      grid[0] = 6;
      grid[1] = 22 + 2 * (v % 7);
      grid[2] = s - 7;
      if (v >= 7 && v <= 13) begin
        r = grid[$urandom_range(0, 2)] + $urandom_range(0, 6) - 3;
        c = grid[$urandom_range(0, 2)] + $urandom_range(0, 6) - 3;
      end else begin
        r = s - 10 + $urandom_range(0, 6);
        c = s - 10 + $urandom_range(0, 6);
      end
      if (r < 0) r = 0;
      if (c < 0) c = 0;
    end else begin
      r = $urandom_range(0, s - 1);
      c = $urandom_range(0, s - 1);
    end
    if ($urandom_range(0, 1)) begin
      tmp = r;
      r = c;
      c = tmp;
    end
    send_query(r[CoordW-1:0], c[CoordW-1:0], gap_pct);
  endtask

  initial begin
    int dir_rows[DirectedCount];
    int dir_cols[DirectedCount];
    int phase_ver[PhaseCount];
    int phase_ecc[PhaseCount];
    int phase_mask[PhaseCount];
    int phase_dtype[PhaseCount];
    int gap_choice[3];
    int v_eff;
    int gap_pct;

    // Directed coordinates and per-phase settings
    dir_rows    = '{0, 255, 0, 255, 3, 1, 3, 41, 6, 6, 8, 37, 8,
                    8, 8, 8, 8, 44, 43, 40, 43, 22, 22, 45, 6, 0};
    dir_cols    = '{0, 255, 255, 0, 3, 1, 41, 3, 8, 9, 6, 8, 0,
                    1, 2, 3, 4, 8, 8, 8, 43, 24, 23, 0, 22, 45};
    phase_ver   = '{0, 1, 2, 6, 7, 13, 14, 40, 63, 41, 0, 0};
    phase_ecc   = '{1, 2, 3, 0, 1, 2, 3, 3, 1, 0, 0, 0};
    phase_mask  = '{1, 2, 4, 7, 3, 5, 6, 7, 0, 2, 0, 0};
    phase_dtype = '{2, 3, 4, 5, 6, 7, 1, 4, 0, 3, 0, 0};
    gap_choice  = '{0, 15, 40};

    // Hold reset, then release at a rising edge
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed queries on a version 7 symbol, every format bit set and the S2_S2 corner code
    program_symbol(7, 3, 7, 1);
    for (int i = 0; i < DirectedCount; i++)
      send_query(dir_rows[i][CoordW-1:0], dir_cols[i][CoordW-1:0], 0);

    // Random phases; the final two use random settings and no idling
    for (int p = 0; p < PhaseCount; p++) begin
      if (p >= 10) begin
        phase_ver[p] = $urandom_range(0, 63);
        phase_ecc[p] = $urandom_range(0, 3);
        phase_mask[p] = $urandom_range(0, 7);
        phase_dtype[p] = $urandom_range(0, 7);
      end
      program_symbol(phase_ver[p], phase_ecc[p], phase_mask[p], phase_dtype[p]);
      v_eff = phase_ver[p];
      if (v_eff < 1) v_eff = 1;
      if (v_eff > MaxVersionDef) v_eff = MaxVersionDef;
      gap_pct = (p >= 10) ? 0 : gap_choice[p % 3];
      for (int n = 0; n < QueriesPerPhase; n++)
        random_query(v_eff, gap_pct);
    end
    start <= 1'b0;

    // Drain, then allow for the pipeline depth before judging
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending_answers.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/qrfp_pkg.sv
rtl/core/qrfp_cfg.sv
rtl/core/qrfp_eval.sv
rtl/core/qr_function_pattern_module_top.sv
tb/sv/tb_qr_function_pattern_module_top.sv
